// ===== src/convex_hull_graham_scan_assert.svh =====
// Assertion macros for the hull block.
`ifndef CONVEX_HULL_GRAHAM_SCAN_ASSERT_SVH
`define CONVEX_HULL_GRAHAM_SCAN_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CHG_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define CHG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== src/chg_pkg.sv =====
`default_nettype none
package chg_pkg;
  localparam int MaxPoints  = 64;
  localparam int CoordWidth = 16;
  localparam int HullMin    = 3;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int CntW       = $clog2(MaxPoints + 1);
  localparam int DiffW      = CoordWidth + 1;
  localparam int SumW       = DiffW + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int CrossW     = ProdW + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // Read/write port of the point store, driven by the controller.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    coord_t wx;
    coord_t wz;
    idx_t   raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== src/chg_point_mem.sv =====
`default_nettype none
module chg_point_mem
  import chg_pkg::*;
(
  input  wire      clk_i,
  input  mem_req_t req_i,
  output coord_t   rx_o,
  output coord_t   rz_o
);
  coord_t mem_x [MaxPoints];
  coord_t mem_z [MaxPoints];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_x[req_i.waddr] <= req_i.wx;
      mem_z[req_i.waddr] <= req_i.wz;
    end
    rx_o <= mem_x[req_i.raddr];
    rz_o <= mem_z[req_i.raddr];
  end
endmodule
`default_nettype wire

// ===== src/chg_idx_mem.sv =====
`default_nettype none
module chg_idx_mem
  import chg_pkg::*;
(
  input  wire  clk_i,
  input  logic we_i,
  input  idx_t waddr_i,
  input  idx_t wdata_i,
  input  idx_t raddr_i,
  output idx_t rdata_o
);
  idx_t mem [MaxPoints];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/convex_hull_graham_scan.sv =====
`default_nettype none
// Graham-scan convex hull. Points stream in on s_axis (one transfer per point); a transfer
// with tlast ends the set. Points within dup_tolerance_i of a stored point on both axes are
// dropped, as are points beyond 64 stored; the latter sets points_dropped on the burst.
// After the last point the hull is emitted on m_axis counter-clockwise from the pivot
// (lowest z, then lowest x), one vertex per transfer, tlast on the final one; with fewer
// than three points the stored points are emitted in arrival order. With N points already
// stored, a point occupies the block for the duplicate walk (one store read per stored
// point). The end of set then adds the pivot search, an insertion sort (at most
// (N-1)(N-2)/2 compare steps, each compare reads one ordering entry and one point through
// the single store port), the seeding of the stack, the scan with its turn tests, and the
// output of each vertex, which m_axis_tready can hold back.
// s_axis_tready is low while a point or a set is being processed.
module convex_hull_graham_scan
  import chg_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         dup_tolerance_we_i,
  input  wire  [15:0] dup_tolerance_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // pt_x [15:0], pt_z [31:16]
  input  wire         s_axis_tlast,   // set_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // hull_x [15:0], hull_z [31:16], vertex_index [37:32], points_dropped [38], [39] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast    // hull_last
);
  `include "convex_hull_graham_scan_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_DUP, S_DUPC, S_STORE, S_PIV, S_PIVC,
    S_SORTI, S_SORTA, S_SORTK, S_SORTR, S_SORTB, S_SORTM, S_SORTD, S_SORTW,
    S_SCINIT, S_SCINIT2, S_SCAN, S_SCC, S_SCT, S_SCO, S_SCO2, S_SCA, S_SCB, S_SCM,
    S_SCD, S_SCPUSH,
    S_OUTR, S_OUTW, S_OUTM, S_OUT
  } state_e;

  state_e state_q;
  logic [15:0] tol_q;
  coord_t nx_q, nz_q;
  logic end_q, dup_q, ovf_q, direct_q;
  cnt_t cnt_q, i_q, j_q, k_q, top_q, oi_q;
  idx_t piv_q, b_q, c_q;
  coord_t ox_q, oz_q, ax_q, az_q, bx_q, bz_q;
  logic signed [ProdW-1:0] p1_q, p2_q;
  mem_req_t req;
  coord_t rx, rz;
  // ordering memory (sorted indices) and scan stack
  logic ow_e, sw_e;
  idx_t ow_a, ow_d, or_a, or_d, sw_a, sw_d, sr_a, sr_d;

  chg_point_mem u_pts (.clk_i, .req_i(req), .rx_o(rx), .rz_o(rz));
  chg_idx_mem u_ord (.clk_i, .we_i(ow_e), .waddr_i(ow_a), .wdata_i(ow_d),
    .raddr_i(or_a), .rdata_o(or_d));
  chg_idx_mem u_stk (.clk_i, .we_i(sw_e), .waddr_i(sw_a), .wdata_i(sw_d),
    .raddr_i(sr_a), .rdata_o(sr_d));

  // duplicate test against the point just read
  logic signed [DiffW-1:0] ndx, ndz;
  logic [DiffW-1:0] adx, adz;
  logic is_dup;
  assign ndx = DiffW'(rx) - DiffW'(nx_q);
  assign ndz = DiffW'(rz) - DiffW'(nz_q);
  assign adx = ndx[DiffW-1] ? DiffW'(-ndx) : DiffW'(ndx);
  assign adz = ndz[DiffW-1] ? DiffW'(-ndz) : DiffW'(ndz);
  assign is_dup = (adx <= DiffW'(tol_q)) && (adz <= DiffW'(tol_q));

  // turn of (o,a,b); on a common ray the L1 length orders by distance
  logic signed [DiffW-1:0] dax, daz, dbx, dbz;
  logic [DiffW-1:0] mag_ax, mag_az, mag_bx, mag_bz;
  logic [SumW-1:0] l1a, l1b;
  logic signed [CrossW-1:0] crs;
  logic goes_first;
  assign dax = DiffW'(ax_q) - DiffW'(ox_q);
  assign daz = DiffW'(az_q) - DiffW'(oz_q);
  assign dbx = DiffW'(bx_q) - DiffW'(ox_q);
  assign dbz = DiffW'(bz_q) - DiffW'(oz_q);
  assign mag_ax = dax[DiffW-1] ? DiffW'(-dax) : DiffW'(dax);
  assign mag_az = daz[DiffW-1] ? DiffW'(-daz) : DiffW'(daz);
  assign mag_bx = dbx[DiffW-1] ? DiffW'(-dbx) : DiffW'(dbx);
  assign mag_bz = dbz[DiffW-1] ? DiffW'(-dbz) : DiffW'(dbz);
  assign l1a = SumW'(mag_ax) + SumW'(mag_az);
  assign l1b = SumW'(mag_bx) + SumW'(mag_bz);
  assign crs = CrossW'(p1_q) - CrossW'(p2_q);
  assign goes_first = (crs > 0) || (crs == 0 && l1a < l1b);

  assign s_axis_tready = (state_q == S_IDLE);

  logic out_wait;
  assign out_wait = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    req = '0;
    req.we = (state_q == S_STORE) && !dup_q && (cnt_q < cnt_t'(MaxPoints));
    req.waddr = cnt_q[IdxW-1:0];
    req.wx = nx_q;
    req.wz = nz_q;
    ow_e = 1'b0; ow_a = k_q[IdxW-1:0]; ow_d = b_q; or_a = '0;
    sw_e = 1'b0; sw_a = top_q[IdxW-1:0]; sw_d = c_q; sr_a = '0;
    unique case (state_q)
      S_DUP, S_PIV, S_SORTI: req.raddr = i_q[IdxW-1:0];
      S_SORTK:   or_a = idx_t'(k_q - cnt_t'(1));
      S_SORTR:   req.raddr = or_d;
      S_SORTD:   ow_e = goes_first;
      S_SORTW: begin
        ow_e = 1'b1; ow_d = i_q[IdxW-1:0];
      end
      S_SCINIT: begin
        sw_e = 1'b1; sw_a = '0; sw_d = piv_q;
      end
      S_SCINIT2: begin
        sw_e = 1'b1; sw_a = idx_t'(1); sw_d = or_d;
      end
      S_SCAN:    or_a = i_q[IdxW-1:0];
      S_SCT:     sr_a = idx_t'(top_q - cnt_t'(2));
      S_SCO: begin
        req.raddr = sr_d; sr_a = idx_t'(top_q - cnt_t'(1));
      end
      S_SCO2:    req.raddr = sr_d;
      S_SCA:     req.raddr = c_q;
      S_SCPUSH:  sw_e = 1'b1;
      S_OUTR:    sr_a = oi_q[IdxW-1:0];
      S_OUTW:    req.raddr = direct_q ? oi_q[IdxW-1:0] : sr_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tol_q <= '0;
      nx_q <= '0; nz_q <= '0;
      end_q <= 1'b0; dup_q <= 1'b0; ovf_q <= 1'b0; direct_q <= 1'b0;
      cnt_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; top_q <= '0; oi_q <= '0;
      piv_q <= '0; b_q <= '0; c_q <= '0;
      ox_q <= '0; oz_q <= '0; ax_q <= '0; az_q <= '0; bx_q <= '0; bz_q <= '0;
      p1_q <= '0; p2_q <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
    end else begin
      if (dup_tolerance_we_i) tol_q <= dup_tolerance_i;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          nx_q <= s_axis_tdata[15:0];
          nz_q <= s_axis_tdata[31:16];
          end_q <= s_axis_tlast;
          dup_q <= 1'b0;
          i_q <= '0;
          state_q <= S_DUP;
        end
        // duplicate walk over the stored points
        S_DUP: state_q <= (i_q == cnt_q) ? S_STORE : S_DUPC;
        S_DUPC: begin
          if (is_dup) dup_q <= 1'b1;
          i_q <= i_q + cnt_t'(1);
          state_q <= S_DUP;
        end
        S_STORE: begin
          if (!dup_q) begin
            if (cnt_q < cnt_t'(MaxPoints)) cnt_q <= cnt_q + cnt_t'(1);
            else ovf_q <= 1'b1;
          end
          i_q <= '0;
          piv_q <= '0;
          state_q <= end_q ? S_PIV : S_IDLE;
        end
        // pivot search; small sets go straight out in arrival order
        S_PIV: begin
          if (cnt_q < cnt_t'(HullMin)) begin
            direct_q <= 1'b1; top_q <= cnt_q; oi_q <= '0; state_q <= S_OUTR;
          end else if (i_q == cnt_q) begin
            direct_q <= 1'b0; i_q <= '0; j_q <= '0; state_q <= S_SORTI;
          end else begin
            state_q <= S_PIVC;
          end
        end
        S_PIVC: begin
          if (i_q == '0 || rz < oz_q || (rz == oz_q && rx < ox_q)) begin
            piv_q <= i_q[IdxW-1:0]; ox_q <= rx; oz_q <= rz;
          end
          i_q <= i_q + cnt_t'(1);
          state_q <= S_PIV;
        end
        // insertion sort by angle about the pivot; j_q entries sorted so far
        S_SORTI: begin
          if (i_q == cnt_q) begin
            state_q <= S_SCINIT;
          end else if (i_q[IdxW-1:0] == piv_q) begin
            i_q <= i_q + cnt_t'(1);
          end else begin
            state_q <= S_SORTA;
          end
        end
        S_SORTA: begin
          ax_q <= rx; az_q <= rz; k_q <= j_q; state_q <= S_SORTK;
        end
        S_SORTK: state_q <= (k_q == '0) ? S_SORTW : S_SORTR;
        S_SORTR: begin
          b_q <= or_d; state_q <= S_SORTB;
        end
        S_SORTB: begin
          bx_q <= rx; bz_q <= rz; state_q <= S_SORTM;
        end
        S_SORTM: begin
          p1_q <= dax * dbz; p2_q <= daz * dbx; state_q <= S_SORTD;
        end
        S_SORTD: begin
          if (goes_first) begin
            k_q <= k_q - cnt_t'(1); state_q <= S_SORTK;
          end else begin
            state_q <= S_SORTW;
          end
        end
        S_SORTW: begin
          i_q <= i_q + cnt_t'(1); j_q <= j_q + cnt_t'(1); state_q <= S_SORTI;
        end
        // scan: stack seeded with pivot and first sorted point
        S_SCINIT: state_q <= S_SCINIT2;
        S_SCINIT2: begin
          top_q <= cnt_t'(2); i_q <= cnt_t'(1); state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (i_q + cnt_t'(1) == cnt_q) begin
            oi_q <= '0; state_q <= S_OUTR;
          end else begin
            state_q <= S_SCC;
          end
        end
        S_SCC: begin
          c_q <= or_d; state_q <= S_SCT;
        end
        S_SCT: state_q <= (top_q < cnt_t'(2)) ? S_SCPUSH : S_SCO;
        S_SCO: state_q <= S_SCO2;
        S_SCO2: begin
          ox_q <= rx; oz_q <= rz; state_q <= S_SCA;
        end
        S_SCA: begin
          ax_q <= rx; az_q <= rz; state_q <= S_SCB;
        end
        S_SCB: begin
          bx_q <= rx; bz_q <= rz; state_q <= S_SCM;
        end
        S_SCM: begin
          p1_q <= dax * dbz; p2_q <= daz * dbx; state_q <= S_SCD;
        end
        S_SCD: begin
          // clockwise or collinear turn pops the stack top
          if (crs <= 0) begin
            top_q <= top_q - cnt_t'(1); state_q <= S_SCT;
          end else begin
            state_q <= S_SCPUSH;
          end
        end
        S_SCPUSH: begin
          top_q <= top_q + cnt_t'(1); i_q <= i_q + cnt_t'(1); state_q <= S_SCAN;
        end
        // output burst, one vertex per transfer
        S_OUTR: state_q <= S_OUTW;
        S_OUTW: state_q <= S_OUTM;
        S_OUTM: begin
          m_axis_tdata <= {1'b0, ovf_q, oi_q[IdxW-1:0], rz, rx};
          m_axis_tlast <= (oi_q + cnt_t'(1) == top_q);
          m_axis_tvalid <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
          if (oi_q + cnt_t'(1) == top_q) begin
            cnt_q <= '0; ovf_q <= 1'b0; state_q <= S_IDLE;
          end else begin
            oi_q <= oi_q + cnt_t'(1); state_q <= S_OUTR;
          end
        end
        default: ;
      endcase
    end
  end

  `CHG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `CHG_ASSERT_NEXT(a_last_hold, clk_i, rst_ni, out_wait, $stable(m_axis_tlast))
  `CHG_ASSERT_IMP(a_in_blocked, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `CHG_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= cnt_t'(MaxPoints))
endmodule
`default_nettype wire
